>>> hdl/e321q_pkg.sv
package e321q_pkg;

	localparam int PART_W    = 34;
	localparam int TRIG_W    = 32;
	localparam int FRAC_BITS = 30;
	localparam int NORM_W    = 32;
	localparam int SQRT_W    = 64;
	localparam int SQRT_STEPS = 32;

	typedef logic signed [PART_W-1:0] part_t;
	typedef logic signed [TRIG_W-1:0] trig_t;

	localparam part_t HALF_PI_Q30 = 34'sd1686629713;
	localparam part_t PI_Q30      = 34'sd3373259426;
	localparam part_t ONE_Q30     = 34'sd1073741824;

	localparam logic [31:0] ATAN_Q30 [32] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
		32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
		32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic  flip;
		part_t x;
		part_t y;
		part_t z;
	} cordic_lane_t;

	// lanes: 0 roll, 1 pitch, 2 yaw
	typedef cordic_lane_t [2:0] cordic_vec_t;

	typedef part_t [3:0] quat_vec_t;

	typedef struct packed {
		logic [SQRT_W-1:0] rem;
		logic [SQRT_W-1:0] root;
		quat_vec_t         q;
	} sqrt_data_t;

	typedef struct packed {
		logic [3:0]        neg;
		logic              zero;
		logic [NORM_W-1:0] norm;
	} div_side_t;

endpackage

>>> hdl/e321q_cordic_cell.sv
module e321q_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_i,
	input  e321q_pkg::cordic_vec_t  d_i,
	output logic                    vld_o,
	output e321q_pkg::cordic_vec_t  d_o
);
	import e321q_pkg::*;

	localparam part_t ATAN_STEP = $signed({2'b00, ATAN_Q30[STAGE]});

	part_t       xs [3];
	part_t       ys [3];
	cordic_vec_t nxt;
	logic        vld_q;
	cordic_vec_t d_q;

	always_comb begin
		nxt = d_i;
		for (int l = 0; l < 3; l++) begin
			xs[l] = d_i[l].x >>> STAGE;
			ys[l] = d_i[l].y >>> STAGE;
			if (!d_i[l].z[PART_W-1]) begin
				nxt[l].x = d_i[l].x - ys[l];
				nxt[l].y = d_i[l].y + xs[l];
				nxt[l].z = d_i[l].z - ATAN_STEP;
			end else begin
				nxt[l].x = d_i[l].x + ys[l];
				nxt[l].y = d_i[l].y - xs[l];
				nxt[l].z = d_i[l].z + ATAN_STEP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign vld_o = vld_q;
	assign d_o   = d_q;

endmodule

>>> hdl/e321q_sqrt_cell.sv
module e321q_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld_i,
	input  e321q_pkg::sqrt_data_t  d_i,
	output logic                   vld_o,
	output e321q_pkg::sqrt_data_t  d_o
);
	import e321q_pkg::*;

	localparam logic [SQRT_W-1:0] BIT = 64'd1 << (62 - 2 * STEP);

	logic [SQRT_W-1:0] trial;
	sqrt_data_t        nxt;
	logic              vld_q;
	sqrt_data_t        d_q;

	always_comb begin
		trial = d_i.root + BIT;
		nxt   = d_i;
		if (d_i.rem >= trial) begin
			nxt.rem  = d_i.rem - trial;
			nxt.root = (d_i.root >> 1) + BIT;
		end else begin
			nxt.root = d_i.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign vld_o = vld_q;
	assign d_o   = d_q;

endmodule

>>> hdl/e321q_div_cell.sv
module e321q_div_cell #(
	parameter int NW   = 48,
	parameter int QB   = 15,
	parameter int STEP = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_i,
	input  logic [3:0][NW-1:0]         rem_i,
	input  logic [3:0][QB-1:0]         quo_i,
	input  e321q_pkg::div_side_t       side_i,
	output logic                       vld_o,
	output logic [3:0][NW-1:0]         rem_o,
	output logic [3:0][QB-1:0]         quo_o,
	output e321q_pkg::div_side_t       side_o
);
	import e321q_pkg::*;

	localparam int K = QB - 1 - STEP;

	logic [NW-1:0]         dsh;
	logic [3:0][NW-1:0]    rem_n;
	logic [3:0][QB-1:0]    quo_n;
	logic                  vld_q;
	logic [3:0][NW-1:0]    rem_q;
	logic [3:0][QB-1:0]    quo_q;
	div_side_t             side_q;

	always_comb begin
		dsh = NW'(side_i.norm) << K;
		for (int l = 0; l < 4; l++) begin
			rem_n[l] = rem_i[l];
			quo_n[l] = quo_i[l];
			if (rem_i[l] >= dsh) begin
				rem_n[l]    = rem_i[l] - dsh;
				quo_n[l][K] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_n;
			quo_q  <= quo_n;
			side_q <= side_i;
		end
	end

	assign vld_o  = vld_q;
	assign rem_o  = rem_q;
	assign quo_o  = quo_q;
	assign side_o = side_q;

endmodule

>>> hdl/euler321_to_quaternion_top.sv
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | roll_angle, pitch_angle, yaw_angle
// out     | out_valid / out_ready| quat_w, quat_x, quat_y, quat_z
//
// One request per cycle unless out_ready holds the pipeline. A request
// passes the CORDIC cells, the 32 square-root cells and one divide cell
// per quotient bit. No state is kept between requests.
// Reset clears only the valid bits along the pipeline.
// The whole pipeline holds while a result waits on out_ready; in_ready
// follows that hold.
module euler321_to_quaternion_top #(
	parameter int ANGLE_WIDTH   = 16,
	parameter int QUAT_WIDTH    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [ANGLE_WIDTH-1:0] roll_angle,
	input  logic signed [ANGLE_WIDTH-1:0] pitch_angle,
	input  logic signed [ANGLE_WIDTH-1:0] yaw_angle,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [QUAT_WIDTH-1:0]  quat_w,
	output logic signed [QUAT_WIDTH-1:0]  quat_x,
	output logic signed [QUAT_WIDTH-1:0]  quat_y,
	output logic signed [QUAT_WIDTH-1:0]  quat_z
);
	import e321q_pkg::*;

	localparam int ASH = 32 - ANGLE_WIDTH;
	localparam int FB  = QUAT_WIDTH - 2;
	localparam int QB  = QUAT_WIDTH - 1;
	localparam int NW  = PART_W + FB + 1;
	localparam logic [QB-1:0] ONE_Q = QB'(1) << FB;

	logic en;

	// fold
	part_t        ang [3];
	cordic_vec_t  fold;
	logic         vld_s1;
	cordic_vec_t  fold_s1;

	always_comb begin
		ang[0] = part_t'(roll_angle) <<< ASH;
		ang[1] = part_t'(pitch_angle) <<< ASH;
		ang[2] = part_t'(yaw_angle) <<< ASH;
		for (int l = 0; l < 3; l++) begin
			fold[l].x    = ONE_Q30;
			fold[l].y    = '0;
			fold[l].z    = ang[l];
			fold[l].flip = 1'b0;
			if (ang[l] > HALF_PI_Q30) begin
				fold[l].z    = ang[l] - PI_Q30;
				fold[l].flip = 1'b1;
			end else if (ang[l] < -HALF_PI_Q30) begin
				fold[l].z    = ang[l] + PI_Q30;
				fold[l].flip = 1'b1;
			end
		end
	end

	// CORDIC row
	cordic_vec_t cd     [CORDIC_STAGES+1];
	logic        cd_vld [CORDIC_STAGES+1];

	assign cd[0]     = fold_s1;
	assign cd_vld[0] = vld_s1;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		e321q_cordic_cell #(.STAGE(i)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.vld_i (cd_vld[i]),
			.d_i   (cd[i]),
			.vld_o (cd_vld[i+1]),
			.d_o   (cd[i+1])
		);
	end

	// cos/sin, products, parts
	logic                  vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	trig_t                 c_s2 [3];
	trig_t                 s_s2 [3];
	logic signed [63:0]    m2 [4];
	part_t                 pr_s3 [4];
	trig_t                 cy_s3, sy_s3;
	logic signed [65:0]    t3 [8];
	part_t                 t_s4 [8];
	quat_vec_t             q_s5;
	logic [PART_W-1:0]     mag5 [4];
	logic [2*PART_W-1:0]   sq5 [4];
	logic [63:0]           sq_s6 [4];
	quat_vec_t             q_s6;
	logic [63:0]           sum_s7;
	quat_vec_t             q_s7;

	always_comb begin
		// cc, ss, sc, cs of roll x pitch
		m2[0] = c_s2[0] * c_s2[1];
		m2[1] = s_s2[0] * s_s2[1];
		m2[2] = s_s2[0] * c_s2[1];
		m2[3] = c_s2[0] * s_s2[1];
		t3[0] = pr_s3[0] * cy_s3;
		t3[1] = pr_s3[1] * sy_s3;
		t3[2] = pr_s3[2] * cy_s3;
		t3[3] = pr_s3[3] * sy_s3;
		t3[4] = pr_s3[3] * cy_s3;
		t3[5] = pr_s3[2] * sy_s3;
		t3[6] = pr_s3[0] * sy_s3;
		t3[7] = pr_s3[1] * cy_s3;
		for (int k = 0; k < 4; k++) begin
			mag5[k] = q_s5[k][PART_W-1] ? PART_W'(-q_s5[k]) : PART_W'(q_s5[k]);
			sq5[k]  = mag5[k] * mag5[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fold_s1 <= fold;
			for (int l = 0; l < 3; l++) begin
				c_s2[l] <= TRIG_W'(cd[CORDIC_STAGES][l].flip ?
					-cd[CORDIC_STAGES][l].x : cd[CORDIC_STAGES][l].x);
				s_s2[l] <= TRIG_W'(cd[CORDIC_STAGES][l].flip ?
					-cd[CORDIC_STAGES][l].y : cd[CORDIC_STAGES][l].y);
			end
			for (int k = 0; k < 4; k++) begin
				pr_s3[k] <= PART_W'(m2[k] >>> FRAC_BITS);
			end
			cy_s3 <= c_s2[2];
			sy_s3 <= s_s2[2];
			for (int k = 0; k < 8; k++) begin
				t_s4[k] <= PART_W'(t3[k] >>> 32);
			end
			q_s5[0] <= t_s4[0] + t_s4[1];
			q_s5[1] <= t_s4[2] - t_s4[3];
			q_s5[2] <= t_s4[4] + t_s4[5];
			q_s5[3] <= t_s4[6] - t_s4[7];
			for (int k = 0; k < 4; k++) begin
				sq_s6[k] <= sq5[k][63:0];
			end
			q_s6   <= q_s5;
			sum_s7 <= sq_s6[0] + sq_s6[1] + sq_s6[2] + sq_s6[3];
			q_s7   <= q_s6;
		end
	end

	// square-root row
	sqrt_data_t sd     [SQRT_STEPS+1];
	logic       sd_vld [SQRT_STEPS+1];

	assign sd[0].rem  = sum_s7;
	assign sd[0].root = '0;
	assign sd[0].q    = q_s7;
	assign sd_vld[0]  = vld_s7;

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		e321q_sqrt_cell #(.STEP(i)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.vld_i (sd_vld[i]),
			.d_i   (sd[i]),
			.vld_o (sd_vld[i+1]),
			.d_o   (sd[i+1])
		);
	end

	// dividend setup
	logic [NORM_W-1:0]  norm8;
	logic [3:0][NW-1:0] num8;
	logic [3:0]         neg8;
	logic [PART_W-1:0]  mag8 [4];
	logic [3:0][NW-1:0] rem_s8;
	div_side_t          side_s8;

	always_comb begin
		norm8 = NORM_W'(sd[SQRT_STEPS].root);
		for (int k = 0; k < 4; k++) begin
			neg8[k] = sd[SQRT_STEPS].q[k][PART_W-1];
			mag8[k] = neg8[k] ? PART_W'(-sd[SQRT_STEPS].q[k]) : PART_W'(sd[SQRT_STEPS].q[k]);
			num8[k] = (NW'(mag8[k]) << FB) + NW'(norm8 >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s8       <= num8;
			side_s8.neg  <= neg8;
			side_s8.norm <= norm8;
			side_s8.zero <= (norm8 == '0);
		end
	end

	// divide row
	logic [3:0][NW-1:0] dv_rem  [QB+1];
	logic [3:0][QB-1:0] dv_quo  [QB+1];
	div_side_t          dv_side [QB+1];
	logic               dv_vld  [QB+1];

	assign dv_rem[0]  = rem_s8;
	assign dv_quo[0]  = '0;
	assign dv_side[0] = side_s8;
	assign dv_vld[0]  = vld_s8;

	for (genvar i = 0; i < QB; i++) begin : g_div
		e321q_div_cell #(.NW(NW), .QB(QB), .STEP(i)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.vld_i (dv_vld[i]),
			.rem_i (dv_rem[i]),
			.quo_i (dv_quo[i]),
			.side_i(dv_side[i]),
			.vld_o (dv_vld[i+1]),
			.rem_o (dv_rem[i+1]),
			.quo_o (dv_quo[i+1]),
			.side_o(dv_side[i+1])
		);
	end

	// saturate, sign, output register
	logic [QB-1:0]                r_sat [4];
	logic signed [QUAT_WIDTH-1:0] qv    [4];
	logic                         out_vld_q;
	logic signed [QUAT_WIDTH-1:0] quat_q [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			r_sat[k] = (dv_quo[QB][k] > ONE_Q) ? ONE_Q : dv_quo[QB][k];
			qv[k]    = dv_side[QB].neg[k] ? -$signed(QUAT_WIDTH'(r_sat[k]))
				: $signed(QUAT_WIDTH'(r_sat[k]));
			if (dv_side[QB].zero) begin
				qv[k] = (k == 0) ? $signed(QUAT_WIDTH'(ONE_Q)) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				quat_q[k] <= qv[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= cd_vld[CORDIC_STAGES];
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			vld_s8    <= sd_vld[SQRT_STEPS];
			out_vld_q <= dv_vld[QB];
		end
	end

	assign en        = !out_vld_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_vld_q;
	assign quat_w    = quat_q[0];
	assign quat_x    = quat_q[1];
	assign quat_y    = quat_q[2];
	assign quat_z    = quat_q[3];

`ifndef SYNTHESIS
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(quat_w) <= $signed(QUAT_WIDTH'(ONE_Q)) &&
			$signed(quat_w) >= -$signed(QUAT_WIDTH'(ONE_Q))))
		else $error("quat_w out of unit range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("pipeline held without a waiting result");
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 |-> !side_s8.zero)
		else $error("zero norm reached the divider");
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_vld[QB] && in_ready) |=> out_valid)
		else $error("finished request lost at output");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import e321q_pkg::*;

	localparam int AW = 16;
	localparam int QW = 16;
	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + QW + 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic signed [63:0] HALF_PI = 64'sd1686629713;
	localparam logic signed [63:0] PI_VAL = 64'sd3373259426;

	typedef struct packed {
		logic signed [AW-1:0] roll;
		logic signed [AW-1:0] pitch;
		logic signed [AW-1:0] yaw;
	} angles_t;

	typedef struct packed {
		logic signed [QW-1:0] w;
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic signed [QW-1:0] z;
	} quat_t;

	typedef struct {
		angles_t a;
		bit known;
		quat_t q;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [AW-1:0] roll_angle;
	logic signed [AW-1:0] pitch_angle;
	logic signed [AW-1:0] yaw_angle;
	logic out_valid;
	logic out_ready;
	logic signed [QW-1:0] quat_w;
	logic signed [QW-1:0] quat_x;
	logic signed [QW-1:0] quat_y;
	logic signed [QW-1:0] quat_z;

	quat_t quat_queue[$];
	int fail_count;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;
	int quiet_cycles;
	bit stim_done;

	euler321_to_quaternion_top #(
		.ANGLE_WIDTH(AW),
		.QUAT_WIDTH(QW),
		.CORDIC_STAGES(STAGES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.roll_angle(roll_angle),
		.pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.quat_w(quat_w),
		.quat_x(quat_x),
		.quat_y(quat_y),
		.quat_z(quat_z)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int s);
		return v >>> s;
	endfunction

	// half-angle cosine and sine, gain left in
	function automatic void half_trig(input logic signed [AW-1:0] ang,
			output logic signed [63:0] c, output logic signed [63:0] s);
		logic signed [63:0] zz;
		logic signed [63:0] xx;
		logic signed [63:0] yy;
		logic signed [63:0] xs;
		logic signed [63:0] ys;
		bit flip;
		zz = 64'(ang) <<< (32 - AW);
		xx = 64'sd1 <<< 30;
		yy = '0;
		flip = 0;
		if (zz > HALF_PI) begin
			zz -= PI_VAL;
			flip = 1;
		end else if (zz < -HALF_PI) begin
			zz += PI_VAL;
			flip = 1;
		end
		for (int i = 0; i < STAGES; i++) begin
			xs = floor_shr(xx, i);
			ys = floor_shr(yy, i);
			if (zz >= 0) begin
				xx -= ys;
				yy += xs;
				zz -= 64'(ATAN_Q30[i]);
			end else begin
				xx += ys;
				yy -= xs;
				zz += 64'(ATAN_Q30[i]);
			end
		end
		c = flip ? -xx : xx;
		s = flip ? -yy : yy;
	endfunction

	function automatic logic signed [63:0] triple(logic signed [63:0] a,
			logic signed [63:0] b, logic signed [63:0] c);
		return floor_shr(floor_shr(a * b, 30) * c, 32);
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] root;
		logic [63:0] b;
		root = '0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic quat_t attitude_quat(angles_t a);
		logic signed [63:0] cr, sr, cp, sp, cy, sy;
		logic signed [63:0] q[4];
		logic [63:0] mag;
		logic [63:0] sum;
		logic [63:0] norm;
		logic [63:0] r;
		logic signed [QW-1:0] v[4];
		quat_t res;
		half_trig(a.roll, cr, sr);
		half_trig(a.pitch, cp, sp);
		half_trig(a.yaw, cy, sy);
		q[0] = triple(cr, cp, cy) + triple(sr, sp, sy);
		q[1] = triple(sr, cp, cy) - triple(cr, sp, sy);
		q[2] = triple(cr, sp, cy) + triple(sr, cp, sy);
		q[3] = triple(cr, cp, sy) - triple(sr, sp, cy);
		sum = '0;
		for (int k = 0; k < 4; k++) begin
			mag = q[k] < 0 ? -q[k] : q[k];
			sum += mag * mag;
		end
		norm = int_sqrt(sum);
		for (int k = 0; k < 4; k++) begin
			if (norm == 0) begin
				v[k] = (k == 0) ? QW'(1 << (QW - 2)) : '0;
			end else begin
				mag = q[k] < 0 ? -q[k] : q[k];
				r = ((mag << (QW - 2)) + (norm >> 1)) / norm;
				if (r > (64'd1 << (QW - 2)))
					r = 64'd1 << (QW - 2);
				v[k] = q[k] < 0 ? -QW'(r) : QW'(r);
			end
		end
		res.w = v[0];
		res.x = v[1];
		res.y = v[2];
		res.z = v[3];
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	// valid stays up between back-to-back requests; the caller drops it before a pause
	task automatic send_request(angles_t a);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		roll_angle <= a.roll;
		pitch_angle <= a.pitch;
		yaw_angle <= a.yaw;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_checked(angles_t a);
		quat_queue.push_back(attitude_quat(a));
		send_request(a);
	endtask

	function automatic angles_t rand_angles();
		angles_t a;
		int mode;
		mode = $urandom_range(3);
		a.roll = AW'($urandom);
		a.pitch = AW'($urandom);
		a.yaw = AW'($urandom);
		// small angles and near the fold points now and then
		if (mode == 0) begin
			a.roll = AW'($urandom_range(400) - 200);
			a.pitch = AW'($urandom_range(400) - 200);
			a.yaw = AW'($urandom_range(400) - 200);
		end else if (mode == 1) begin
			a.pitch = AW'((($urandom_range(1)) ? 16'sd25736 : -16'sd25736)
				+ $urandom_range(20) - 10);
		end
		return a;
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++)
			send_checked(rand_angles());
	endtask

	// receiver: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		quat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (quat_queue.size() == 0) begin
				report_mismatch("unexpected result", quat_w, 0);
			end else begin
				want = quat_queue.pop_front();
				if (quat_w !== want.w)
					report_mismatch("quat_w", quat_w, want.w);
				if (quat_x !== want.x)
					report_mismatch("quat_x", quat_x, want.x);
				if (quat_y !== want.y)
					report_mismatch("quat_y", quat_y, want.y);
				if (quat_z !== want.z)
					report_mismatch("quat_z", quat_z, want.z);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| stim_done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired");
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		quat_t ident;
		quat_t got_q;
		int waited;

		arst_n = 1'b0;
		in_valid = 1'b0;
		roll_angle = '0;
		pitch_angle = '0;
		yaw_angle = '0;
		fail_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 0;
		stim_done = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		ident = '{w: 16'sd16384, x: 16'sd0, y: 16'sd0, z: 16'sd0};
		// directed table: zero angles give the identity
		rows.push_back('{a: '{16'sd0, 16'sd0, 16'sd0}, known: 1, q: ident});
		rows.push_back('{a: '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, known: 0, q: ident});
		rows.push_back('{a: '{-16'sh8000, -16'sh8000, -16'sh8000}, known: 0, q: ident});
		rows.push_back('{a: '{16'sh7FFF, -16'sh8000, 16'sd0}, known: 0, q: ident});
		rows.push_back('{a: '{16'sd0, 16'sd12868, 16'sd0}, known: 0, q: ident});
		rows.push_back('{a: '{16'sd0, -16'sd12868, 16'sd0}, known: 0, q: ident});
		rows.push_back('{a: '{16'sd25736, 16'sd0, 16'sd0}, known: 0, q: ident});
		rows.push_back('{a: '{16'sd0, 16'sd0, -16'sd25736}, known: 0, q: ident});
		rows.push_back('{a: '{16'sd25737, 16'sd25735, -16'sd25737}, known: 0, q: ident});
		rows.push_back('{a: '{16'sd0, 16'sd12868, 16'sd25736}, known: 0, q: ident});
		rows.push_back('{a: '{16'sd1, -16'sd1, 16'sd1}, known: 0, q: ident});
		rows.push_back('{a: '{16'sh5555, 16'shAAAA, 16'sh5555}, known: 0, q: ident});
		rows.push_back('{a: '{16'shAAAA, 16'sh5555, 16'shAAAA}, known: 0, q: ident});
		rows.push_back('{a: '{16'sd8192, 16'sd8192, 16'sd8192}, known: 0, q: ident});
		foreach (rows[i]) begin
			r = rows[i];
			got_q = attitude_quat(r.a);
			if (r.known && got_q != r.q)
				$display("note: table row %0d differs from predictor", i);
			quat_queue.push_back(r.known ? r.q : got_q);
			send_request(r.a);
		end

		send_idle_pct = 18;
		recv_idle_pct = 51;
		run_random(160);

		// long receiver hold-off while requests keep coming
		in_valid <= 1'b0;
		@(negedge clk);
		hold_cycles = 300;
		run_random(100);

		// sender pauses until the pipeline drains
		in_valid <= 1'b0;
		while (quat_queue.size() != 0)
			@(negedge clk);

		send_idle_pct = 51;
		recv_idle_pct = 18;
		run_random(120);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(120);
		in_valid <= 1'b0;

		waited = 0;
		while (quat_queue.size() != 0 && waited < 20 * LATENCY + WATCHDOG_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		stim_done = 1;
		repeat (LATENCY + 10) @(posedge clk);
		if (quat_queue.size() != 0) begin
			$display("%0d results never arrived", quat_queue.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule

>>> euler321_to_quaternion_top.f
hdl/e321q_pkg.sv
hdl/e321q_cordic_cell.sv
hdl/e321q_sqrt_cell.sv
hdl/e321q_div_cell.sv
hdl/euler321_to_quaternion_top.sv
dv/tb_top.sv
